### hw/rtl/fsa_pkg.sv
package fsa_pkg;

   localparam int MaxSegmentsDefault = 16;
   localparam int AddrBitsDefault    = 16;
   localparam int SizeBits           = 16;
   localparam logic [SizeBits-1:0] SizeLimit = 16'hFFFF;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusNoFit   = 2'd1;
   localparam logic [1:0] StatusFull    = 2'd2;

   localparam logic [1:0] PolicyFirst = 2'd0;
   localparam logic [1:0] PolicyBest  = 2'd1;
   localparam logic [1:0] PolicyWorst = 2'd2;
   localparam logic [1:0] PolicyNext  = 2'd3;

   localparam logic CsrFitPolicy   = 1'b0;
   localparam logic CsrHeaderBytes = 1'b1;

   localparam logic ModeAlloc = 1'b0;
   localparam logic ModeFree  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_ALLOC_RD,
      ST_ALLOC,
      ST_FREE_RD,
      ST_FREE_EVAL,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_COMMIT,
      ST_RESP
   } state_type;

endpackage

### hw/rtl/free_segment_allocator_core.sv
// Free-segment allocator.
// Request channel (req_valid/req_stall): req_mode 0 allocates req_request_size
// payload bytes with the policy in csr register 0; req_mode 1 frees the block
// at req_block_address of req_request_size bytes, merging with free neighbors.
// Response channel (rsp_valid/rsp_stall): one item per request carrying
// status, granted payload address and granted size.
// CSR channel (csr_valid/csr_ready): index 0 fit policy, index 1 header bytes.
// Write only while no request is in flight.
// One request at a time. The segment table sits in two RAMs with registered
// reads and every pass walks it one entry at a time, a read state then an
// evaluate or write state, through one shared comparator: allocate scans the
// table and shifts the entries down when a whole segment is removed; free
// scans it and shifts entries to insert or remove one. The response waits in
// ST_RESP while rsp_stall is high.
// Reset empties the table, points the next-fit cursor at entry 0 and loads
// policy first fit and 16 header bytes. The response is held in a register
// while rsp_stall is high; no new request is taken until it is delivered.
module free_segment_allocator_core
   import fsa_pkg::*;
#(
   parameter int MAX_SEGMENTS = MaxSegmentsDefault,
   parameter int ADDR_BITS    = AddrBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic [15:0]              req_request_size,
   input  logic [15:0]              req_block_address,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic [15:0]              rsp_granted_address,
   output logic [15:0]              rsp_granted_size,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [6:0]               csr_data
);

   localparam int IdxBits = $clog2(MAX_SEGMENTS);
   localparam int CntBits = $clog2(MAX_SEGMENTS + 1);
   localparam int AB = ADDR_BITS;

   state_type state_ff, state_in;

   logic [1:0]          policy_ff;
   logic [6:0]          hdr_ff;
   logic [CntBits-1:0]  count_ff, count_in;
   logic [IdxBits-1:0]  cursor_ff, cursor_in;

   logic [15:0]         req_ff;
   logic [AB-1:0]       node_ff;

   logic [CntBits-1:0]  i_ff, i_in;
   logic [CntBits-1:0]  pick_ff, pick_in;
   logic [15:0]         pick_size_ff, pick_size_in;
   logic                wrapped_ff, wrapped_in;
   // previous entry seen during free scan
   logic [AB-1:0]       prv_start_ff, prv_start_in;
   logic [15:0]         prv_size_ff, prv_size_in;

   // shift pass: dir 1 = remove (move down), 0 = insert (move up)
   logic                shdir_ff, shdir_in;
   logic [CntBits-1:0]  shend_ff, shend_in;
   logic [AB-1:0]       ins_start_ff, ins_start_in;
   logic [15:0]         ins_size_ff, ins_size_in;

   logic [1:0]          st_ff, st_in;
   logic [15:0]         ga_ff, ga_in;
   logic [15:0]         gs_ff, gs_in;

   logic                wr_en;
   logic [IdxBits-1:0]  wr_addr, rd_addr;
   logic [AB-1:0]       wr_start, rd_start;
   logic [15:0]         wr_size, rd_size;

   fsa_ram #(.Width(AB), .Depth(MAX_SEGMENTS)) u_start_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_start),
      .rd_addr(rd_addr), .rd_data(rd_start));
   fsa_ram #(.Width(16), .Depth(MAX_SEGMENTS)) u_size_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_size),
      .rd_addr(rd_addr), .rd_data(rd_size));

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_status = st_ff;
   assign rsp_granted_address = ga_ff;
   assign rsp_granted_size = gs_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         policy_ff <= PolicyFirst;
         hdr_ff    <= 7'd16;
         count_ff  <= '0;
         cursor_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         if (csr_valid) begin
            case (csr_index)
               CsrFitPolicy:   policy_ff <= csr_data[1:0];
               CsrHeaderBytes: hdr_ff    <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff  <= req_request_size;
         node_ff <= AB'(req_block_address) - AB'(hdr_ff);
      end
      i_ff <= i_in;
      pick_ff <= pick_in;
      pick_size_ff <= pick_size_in;
      wrapped_ff <= wrapped_in;
      prv_start_ff <= prv_start_in;
      prv_size_ff <= prv_size_in;
      shdir_ff <= shdir_in;
      shend_ff <= shend_in;
      ins_start_ff <= ins_start_in;
      ins_size_ff <= ins_size_in;
      st_ff <= st_in;
      ga_ff <= ga_in;
      gs_ff <= gs_in;
   end

   // shared 18-bit sums
   logic [17:0] need;        // req + header
   logic        fits;
   logic        better;
   logic [17:0] mp_sum, mn_sum, tri_sum;
   logic        mp, mn;
   logic [CntBits-1:0] p_idx;

   assign need = 18'(req_ff) + 18'(hdr_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cursor_in = cursor_ff;
      i_in = i_ff;
      pick_in = pick_ff;
      pick_size_in = pick_size_ff;
      wrapped_in = wrapped_ff;
      prv_start_in = prv_start_ff;
      prv_size_in = prv_size_ff;
      shdir_in = shdir_ff;
      shend_in = shend_ff;
      ins_start_in = ins_start_ff;
      ins_size_in = ins_size_ff;
      st_in = st_ff;
      ga_in = ga_ff;
      gs_in = gs_ff;
      wr_en = 1'b0;
      wr_addr = i_ff[IdxBits-1:0];
      wr_start = ins_start_ff;
      wr_size = ins_size_ff;
      rd_addr = i_ff[IdxBits-1:0];
      fits = (rd_size >= req_ff);
      better = 1'b0;
      p_idx = i_ff;
      mp_sum = 18'(prv_size_ff) + 18'(req_ff) + 18'(hdr_ff);
      mn_sum = 18'(rd_size) + 18'(req_ff) + 18'(hdr_ff);
      tri_sum = mp_sum + 18'(rd_size) + 18'(hdr_ff);
      mp = 1'b0;
      mn = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               st_in = StatusOk;
               ga_in = '0;
               gs_in = '0;
               pick_in = count_ff;
               wrapped_in = 1'b0;
               if (req_mode == ModeFree) begin
                  i_in = '0;
                  state_in = ST_FREE_RD;
               end else begin
                  if (policy_ff == PolicyNext && CntBits'(cursor_ff) < count_ff) begin
                     i_in = CntBits'(cursor_ff);
                  end else begin
                     i_in = '0;
                     wrapped_in = 1'b1;
                  end
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (i_ff >= count_ff || (wrapped_ff && policy_ff == PolicyNext &&
                                     i_ff >= CntBits'(cursor_ff) &&
                                     CntBits'(cursor_ff) < count_ff)) begin
               if (policy_ff == PolicyNext && !wrapped_ff) begin
                  wrapped_in = 1'b1;
                  i_in = '0;
               end else if (pick_ff >= count_ff) begin
                  st_in = StatusNoFit;
                  state_in = ST_RESP;
               end else begin
                  i_in = pick_ff;
                  state_in = ST_ALLOC_RD;
               end
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            case (policy_ff)
               PolicyBest:  better = (pick_ff >= count_ff) || rd_size < pick_size_ff;
               PolicyWorst: better = (pick_ff >= count_ff) || rd_size > pick_size_ff;
               default:     better = 1'b1;
            endcase
            if (fits && better) begin
               pick_in = i_ff;
               pick_size_in = rd_size;
            end
            if (fits && (policy_ff == PolicyFirst || policy_ff == PolicyNext)) begin
               state_in = ST_ALLOC_RD;
               i_in = i_ff;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_ALLOC_RD: begin
            i_in = pick_ff;
            state_in = ST_ALLOC;
         end
         ST_ALLOC: begin
            ga_in = 16'(rd_start + AB'(hdr_ff));
            if (18'(rd_size) > need) begin
               gs_in = req_ff;
               wr_en = 1'b1;
               wr_addr = pick_ff[IdxBits-1:0];
               wr_start = rd_start + AB'(hdr_ff) + AB'(req_ff);
               wr_size = 16'(18'(rd_size) - need);
               cursor_in = pick_ff[IdxBits-1:0];
               state_in = ST_RESP;
            end else begin
               gs_in = rd_size;
               cursor_in = (pick_ff + 1'b1 < count_ff) ? pick_ff[IdxBits-1:0] : '0;
               shdir_in = 1'b1;
               shend_in = count_ff - 1'b1;
               count_in = count_ff - 1'b1;
               i_in = pick_ff + 1'b1;
               state_in = ST_SHIFT_RD;
            end
         end
         ST_FREE_RD: begin
            // read entry i (registered); decide on arrival
            state_in = ST_FREE_EVAL;
         end
         ST_FREE_EVAL: begin
            p_idx = i_ff;
            if (i_ff < count_ff && rd_start <= node_ff) begin
               prv_start_in = rd_start;
               prv_size_in = rd_size;
               i_in = i_ff + 1'b1;
               state_in = ST_FREE_RD;
            end else begin
               mp = (p_idx != '0) && (prv_start_ff + AB'(hdr_ff) + AB'(prv_size_ff) == node_ff)
                    && mp_sum <= 18'(SizeLimit);
               mn = (p_idx < count_ff) &&
                    (node_ff + AB'(hdr_ff) + AB'(req_ff) == rd_start) &&
                    mn_sum <= 18'(SizeLimit);
               if (mp && mn && tri_sum > 18'(SizeLimit)) mn = 1'b0;
               if (mp && mn) begin
                  wr_en = 1'b1;
                  wr_addr = IdxBits'(p_idx - 1'b1);
                  wr_start = prv_start_ff;
                  wr_size = 16'(tri_sum);
                  if (CntBits'(cursor_ff) > p_idx) cursor_in = cursor_ff - 1'b1;
                  else if (CntBits'(cursor_ff) == p_idx) cursor_in = IdxBits'(p_idx - 1'b1);
                  shdir_in = 1'b1;
                  shend_in = count_ff - 1'b1;
                  count_in = count_ff - 1'b1;
                  i_in = p_idx + 1'b1;
                  state_in = ST_SHIFT_RD;
               end else if (mp) begin
                  wr_en = 1'b1;
                  wr_addr = IdxBits'(p_idx - 1'b1);
                  wr_start = prv_start_ff;
                  wr_size = 16'(mp_sum);
                  state_in = ST_RESP;
               end else if (mn) begin
                  wr_en = 1'b1;
                  wr_addr = p_idx[IdxBits-1:0];
                  wr_start = node_ff;
                  wr_size = 16'(mn_sum);
                  state_in = ST_RESP;
               end else if (count_ff >= CntBits'(MAX_SEGMENTS)) begin
                  st_in = StatusFull;
                  state_in = ST_RESP;
               end else begin
                  if (CntBits'(cursor_ff) >= p_idx && CntBits'(cursor_ff) < count_ff)
                     cursor_in = cursor_ff + 1'b1;
                  // insert by carrying entries upward from p
                  ins_start_in = node_ff;
                  ins_size_in = req_ff;
                  shdir_in = 1'b0;
                  shend_in = count_ff;
                  count_in = count_ff + 1'b1;
                  i_in = p_idx;
                  state_in = ST_SHIFT_RD;
               end
            end
         end
         ST_SHIFT_RD: begin
            // remove: i walks up to shend = old count - 1; insert: i walks up to shend = old count
            if (shdir_ff ? (i_ff > shend_ff) : (i_ff > shend_ff)) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            wr_en = 1'b1;
            if (shdir_ff) begin
               wr_addr = IdxBits'(i_ff - 1'b1);
               wr_start = rd_start;
               wr_size = rd_size;
            end else begin
               // write carried entry at i, carry old contents upward
               wr_addr = i_ff[IdxBits-1:0];
               ins_start_in = rd_start;
               ins_size_in = rd_size;
            end
            i_in = i_ff + 1'b1;
            state_in = ST_SHIFT_RD;
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### hw/rtl/fsa_ram.sv
module fsa_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### bench/free_segment_allocator_core_tb.sv
`timescale 1ns / 1ps

module free_segment_allocator_core_tb;
   import fsa_pkg::*;

   localparam int NumSeg = 16;

   typedef struct {
      logic        mode;
      logic [15:0] size;
      logic [15:0] addr;
   } alloc_req_type;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] gaddr;
      logic [15:0] gsize;
   } alloc_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_mode = 0;
   logic [15:0] req_request_size = 0;
   logic [15:0] req_block_address = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_status;
   logic [15:0] rsp_granted_address;
   logic [15:0] rsp_granted_size;
   logic csr_valid = 0;
   logic csr_ready;
   logic csr_index = 0;
   logic [6:0] csr_data = 0;

   free_segment_allocator_core uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // shadow allocator state
   logic [15:0] seg_start [NumSeg];
   logic [15:0] seg_size [NumSeg];
   int seg_cnt;
   int cursor;
   logic [1:0] policy;
   int hdr;

   alloc_req_type pending_reqs [$];
   alloc_rsp_type expected_rsps [$];
   int errors = 0;
   int rsp_seen = 0;
   int n_alloc_ok = 0;
   int n_nofit = 0;
   int n_full = 0;

   // driver burst state
   int burst_left = 0;
   int gap_left = 0;

   task automatic report(input string what, input int got, input int want);
      $display("MISMATCH @%0t %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   function automatic void drop_entry(input int r);
      for (int i = r; i < seg_cnt - 1; i++) begin
         seg_start[i] = seg_start[i+1];
         seg_size[i] = seg_size[i+1];
      end
      seg_cnt--;
   endfunction

   function automatic alloc_rsp_type predict_alloc(input int req);
      alloc_rsp_type r;
      int pick;
      int lim;
      pick = seg_cnt;
      r = '{StatusNoFit, 16'd0, 16'd0};
      case (policy)
         PolicyFirst: begin
            for (int i = 0; i < seg_cnt; i++)
               if (seg_size[i] >= req && pick == seg_cnt) pick = i;
         end
         PolicyBest, PolicyWorst: begin
            for (int i = 0; i < seg_cnt; i++) begin
               if (seg_size[i] < req) continue;
               if (pick == seg_cnt || (policy == PolicyBest ? seg_size[i] < seg_size[pick]
                                                            : seg_size[i] > seg_size[pick]))
                  pick = i;
            end
         end
         default: begin
            lim = cursor < seg_cnt ? cursor : seg_cnt;
            for (int i = cursor; i < seg_cnt; i++)
               if (seg_size[i] >= req && pick == seg_cnt) pick = i;
            if (pick == seg_cnt)
               for (int i = 0; i < lim; i++)
                  if (seg_size[i] >= req && pick == seg_cnt) pick = i;
         end
      endcase
      if (pick >= seg_cnt) return r;
      r.status = StatusOk;
      r.gaddr = seg_start[pick] + 16'(hdr);
      if (int'(seg_size[pick]) > req + hdr) begin
         r.gsize = 16'(req);
         seg_start[pick] = seg_start[pick] + 16'(hdr + req);
         seg_size[pick] = seg_size[pick] - 16'(req + hdr);
         cursor = pick;
      end else begin
         r.gsize = seg_size[pick];
         drop_entry(pick);
         cursor = pick < seg_cnt ? pick : 0;
      end
      return r;
   endfunction

   function automatic alloc_rsp_type predict_free(input int sz, input logic [15:0] baddr);
      alloc_rsp_type r;
      logic [15:0] node;
      int p;
      bit mp, mn;
      r = '{StatusOk, 16'd0, 16'd0};
      node = baddr - 16'(hdr);
      p = 0;
      while (p < seg_cnt && seg_start[p] <= node) p++;
      mp = p > 0 && 16'(seg_start[p-1] + 16'(hdr) + seg_size[p-1]) == node
           && int'(seg_size[p-1]) + sz + hdr <= 65535;
      mn = p < seg_cnt && 16'(node + 16'(hdr) + 16'(sz)) == seg_start[p]
           && int'(seg_size[p]) + sz + hdr <= 65535;
      if (mp && mn && int'(seg_size[p-1]) + sz + int'(seg_size[p]) + 2 * hdr > 65535)
         mn = 0;
      if (mp && mn) begin
         seg_size[p-1] = 16'(int'(seg_size[p-1]) + sz + int'(seg_size[p]) + 2 * hdr);
         drop_entry(p);
         if (cursor > p) cursor--;
         else if (cursor == p) cursor = p - 1;
      end else if (mp) begin
         seg_size[p-1] = 16'(int'(seg_size[p-1]) + sz + hdr);
      end else if (mn) begin
         seg_start[p] = node;
         seg_size[p] = 16'(int'(seg_size[p]) + sz + hdr);
      end else begin
         if (seg_cnt >= NumSeg) begin
            r.status = StatusFull;
            return r;
         end
         for (int i = seg_cnt; i > p; i--) begin
            seg_start[i] = seg_start[i-1];
            seg_size[i] = seg_size[i-1];
         end
         seg_start[p] = node;
         seg_size[p] = 16'(sz);
         if (cursor >= p && cursor < seg_cnt) cursor++;
         seg_cnt++;
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left > 0 || pending_reqs.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_valid <= 0;
         end else begin
            alloc_req_type it;
            it = pending_reqs.pop_front();
            req_valid <= 1;
            req_mode <= it.mode;
            req_request_size <= it.size;
            req_block_address <= it.addr;
            if (it.mode == ModeAlloc) expected_rsps.push_back(predict_alloc(int'(it.size)));
            else expected_rsps.push_back(predict_free(int'(it.size), it.addr));
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 6);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            end
         end
      end
   end

   // monitor and stall pattern
   int stall_mode = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            alloc_rsp_type e;
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               report("unexpected item", 0, 0);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status != e.status) report("status", rsp_status, e.status);
               if (rsp_granted_address != e.gaddr)
                  report("granted_address", rsp_granted_address, e.gaddr);
               if (rsp_granted_size != e.gsize)
                  report("granted_size", rsp_granted_size, e.gsize);
               case (e.status)
                  StatusOk: if (e.gsize != 0) n_alloc_ok++;
                  StatusNoFit: n_nofit++;
                  default: n_full++;
               endcase
            end
         end
         if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 9) > 2);
         endcase
      end
   end

   task automatic csr_write(input logic idx, input int val);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= 7'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == CsrFitPolicy) policy = 2'(val);
      else hdr = val;
   endtask

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic void push_req(input logic m, input int sz, input int ad);
      pending_reqs.push_back('{m, 16'(sz), 16'(ad)});
   endfunction

   // random allocs and frees of small adjacent and scattered blocks; mostly well formed
   function automatic void rand_phase(input int cnt);
      int base;
      for (int k = 0; k < cnt; k++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: push_req(ModeAlloc, $urandom_range(0, 300), $urandom);
            4: push_req(ModeAlloc, $urandom, $urandom);
            5, 6: begin
               base = $urandom_range(0, 63) * 512 + $urandom_range(0, 3) * 128;
               push_req(ModeFree, $urandom_range(32, 400), base + hdr);
            end
            7: push_req(ModeFree, 128 - hdr,
                        $urandom_range(0, 255) * 128 + hdr); // tiles merge exactly
            8: push_req(ModeFree, $urandom_range(60000, 65535), $urandom);
            default: push_req(ModeFree, $urandom, $urandom);
         endcase
      end
   endfunction

   initial begin
      seg_cnt = 0;
      cursor = 0;
      policy = PolicyFirst;
      hdr = 16;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: empty table, extremes, merges, wrap, full table
      push_req(ModeAlloc, 10, 0);
      push_req(ModeFree, 100, 16'h0010);
      push_req(ModeFree, 100, 16'h0010 + 116);  // merges with lower
      push_req(ModeFree, 50, 16'h0400);
      push_req(ModeFree, 50, 16'h0400 - 66);    // merges with upper
      push_req(ModeAlloc, 0, 16'hFFFF);
      push_req(ModeAlloc, 65535, 0);
      push_req(ModeAlloc, 200, 0);
      push_req(ModeFree, 65535, 16'h0008);      // wraps, overflow guard
      push_req(ModeFree, 65535, 16'hFFFF);
      push_req(ModeFree, 0, 16'h0000);
      for (int i = 0; i < 16; i++) push_req(ModeFree, 8, 16'h2000 + i * 64);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CsrFitPolicy, ph % 4);
         csr_write(CsrHeaderBytes, ph == 0 ? 0 : ph == 1 ? 64 : ph == 5 ? 127
                                  : $urandom_range(0, 64));
         rand_phase(50);
         drain();
      end
      $display("Covered %0d responses: %0d allocations granted, %0d no-fit, %0d table-full",
               rsp_seen, n_alloc_ok, n_nofit, n_full);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d items outstanding", expected_rsps.size());
      $display("Verification failed");
      $finish;
   end

endmodule
